// ===== sv/bpgs_pkg.sv =====
// Shared types and codes for the border padding gather/scatter block.
`default_nettype none
package bpgs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int COORD_W  = 8;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACCUM = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd3;

  // Configuration reset values.
  localparam logic [7:0] RST_WIDTH  = 8'd128;
  localparam logic [7:0] RST_HEIGHT = 8'd128;
  localparam logic [4:0] RST_PAD    = 5'd0;
  localparam logic       RST_MODE   = 1'b0;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [STAT_W-1:0]          status;
    logic                       in_border;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic load_dec;
    logic commit;
  } ctl_t;

endpackage
`default_nettype wire

// ===== sv/bpgs_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module bpgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/bpgs_ctrl.sv =====
// Controller state machine: sequences decode, memory read and commit per request.
`default_nettype none
module bpgs_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bpgs_pkg::ctl_t   ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // Commit only once the result register is free or being drained.
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_RD;
      S_RD:   state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign ctl.load_req = accept;
  assign ctl.load_dec = (state_r == S_DEC);
  assign ctl.commit   = commit;

  a_accept_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DEC))
    else $error("accepted request did not enter decode");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && !out_ready) |=> (state_r == S_EXEC && out_valid_r))
    else $error("result committed over a waiting result");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not present a result");

endmodule
`default_nettype wire

// ===== sv/bpgs_datapath.sv =====
// Datapath: configuration, coordinate decode, model memory and saturating update.
`default_nettype none
module bpgs_datapath #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int MAX_PAD     = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [bpgs_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [bpgs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire bpgs_pkg::in_req_t                    in_data,
  input  wire bpgs_pkg::ctl_t                       ctl,
  output bpgs_pkg::out_rsp_t                        out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int XB    = ((SB > 32) ? SB : 32) + 2;
  localparam logic signed [XB-1:0] SMAX = $signed((XB'(1) << (SB - 1)) - XB'(1));
  localparam logic signed [XB-1:0] SMIN = -SMAX - XB'(1);

  // Configuration registers.
  logic [7:0] width_r, height_r;
  logic [4:0] pad_r;
  logic       mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bpgs_pkg::RST_WIDTH;
      height_r <= bpgs_pkg::RST_HEIGHT;
      pad_r    <= bpgs_pkg::RST_PAD;
      mode_r   <= bpgs_pkg::RST_MODE;
    end else if (cfg_we) begin
      case (cfg_addr)
        bpgs_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        bpgs_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        bpgs_pkg::CFG_PAD:    pad_r    <= cfg_wdata[4:0];
        bpgs_pkg::CFG_MODE:   mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to the array limits.
  logic [7:0] w_c, h_c;
  logic [4:0] p_c;

  always_comb begin
    w_c = width_r;
    if (width_r == 8'd0) w_c = 8'd1;
    else if (int'(width_r) > MAX_WIDTH) w_c = 8'(MAX_WIDTH);
    h_c = height_r;
    if (height_r == 8'd0) h_c = 8'd1;
    else if (int'(height_r) > MAX_HEIGHT) h_c = 8'(MAX_HEIGHT);
    p_c = pad_r;
    if (int'(pad_r) > MAX_PAD) p_c = 5'(MAX_PAD);
  end

  // Request register.
  bpgs_pkg::in_req_t req_r;

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_r <= in_data;
    end
  end

  // Coordinate decode.
  logic [9:0]    row_x, col_x, p_x, row_lim, col_lim;
  logic          outside_nxt, border_nxt;
  logic          row_lo, row_hi, col_lo, col_hi;
  logic [7:0]    mr, mc;
  logic [AW-1:0] idx_nxt;

  always_comb begin
    row_x   = 10'(req_r.row);
    col_x   = 10'(req_r.col);
    p_x     = 10'(p_c);
    row_lim = 10'(h_c) + p_x;
    col_lim = 10'(w_c) + p_x;
    outside_nxt = (row_x >= row_lim + p_x) || (col_x >= col_lim + p_x);
    row_lo = row_x < p_x;
    row_hi = row_x >= row_lim;
    col_lo = col_x < p_x;
    col_hi = col_x >= col_lim;
    border_nxt = row_lo || row_hi || col_lo || col_hi;
    mr = row_lo ? 8'd0 : (row_hi ? h_c - 8'd1 : req_r.row - 8'(p_c));
    mc = col_lo ? 8'd0 : (col_hi ? w_c - 8'd1 : req_r.col - 8'(p_c));
    idx_nxt = AW'(32'(mr) * 32'(MAX_WIDTH) + 32'(mc));
  end

  logic [AW-1:0] idx_r;
  logic          outside_r, border_r;

  always_ff @(posedge clk) begin
    if (ctl.load_dec) begin
      idx_r     <= idx_nxt;
      outside_r <= outside_nxt;
      border_r  <= border_nxt;
    end
  end

  // Model memory: read address held on the decoded entry until commit.
  logic          ram_we;
  logic [SB-1:0] ram_wdata, ram_rdata;

  bpgs_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Execute: saturating write or accumulate.
  logic signed [XB-1:0] smp_x, smp_c, ent_x, sum_x, val_x;
  logic [bpgs_pkg::STAT_W-1:0] stat_nxt;
  logic                 wr_en;
  logic                 live;

  always_comb begin
    smp_x = XB'(req_r.sample_in);
    if (smp_x > SMAX)      smp_c = SMAX;
    else if (smp_x < SMIN) smp_c = SMIN;
    else                   smp_c = smp_x;
    ent_x = XB'($signed(ram_rdata));
    sum_x = ent_x + smp_c;
    live  = !border_r || mode_r;
    val_x    = '0;
    stat_nxt = bpgs_pkg::ST_OK;
    wr_en    = 1'b0;
    if (outside_r) begin
      stat_nxt = bpgs_pkg::ST_RANGE;
    end else begin
      case (req_r.action)
        bpgs_pkg::ACT_WRITE: begin
          if (border_r) begin
            stat_nxt = bpgs_pkg::ST_RANGE;
          end else begin
            val_x = smp_c;
            wr_en = 1'b1;
          end
        end
        bpgs_pkg::ACT_READ: begin
          if (live) val_x = ent_x;
        end
        bpgs_pkg::ACT_ACCUM: begin
          if (live) begin
            wr_en = 1'b1;
            if (sum_x > SMAX) begin
              val_x    = SMAX;
              stat_nxt = bpgs_pkg::ST_SAT;
            end else if (sum_x < SMIN) begin
              val_x    = SMIN;
              stat_nxt = bpgs_pkg::ST_SAT;
            end else begin
              val_x = sum_x;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign ram_we    = ctl.commit && wr_en;
  assign ram_wdata = val_x[SB-1:0];

  // Result register.
  bpgs_pkg::out_rsp_t out_r;

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_r.sample_out <= val_x[bpgs_pkg::SAMPLE_W-1:0];
      out_r.status     <= stat_nxt;
      out_r.in_border  <= border_r && !outside_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== sv/border_pad_gather_scatter.sv =====
// Top level of the border padding gather/scatter block.
//
// Holds a model image of up to MAX_HEIGHT x MAX_WIDTH signed samples and
// serves requests addressed in a padded frame with pad_size cells on every
// side. A write stores at an interior cell, a forward read returns the cell
// (zero or the clamped edge cell in the border, by pad_mode), and an adjoint
// accumulate adds into the clamped cell with saturation (dropped in the border
// in zero mode). Each request passes through the accept cycle, coordinate
// decode, memory read, then execute with write-back, all through the one
// read and one write port of the model memory. The next request is taken
// only after the current result is loaded into the output register, so
// requests never overlap in the block. A result waiting in the output
// register does not stop the next request from being accepted and decoded;
// only its commit waits. The model memory has no clearing pass: entries
// read before they are written return undefined values. Configuration
// writes take effect at once and are meant for idle periods.
`default_nettype none
module border_pad_gather_scatter #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int MAX_PAD     = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [bpgs_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [bpgs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Request channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bpgs_pkg::in_req_t                in_data,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output bpgs_pkg::out_rsp_t                    out_data
);

  bpgs_pkg::ctl_t ctl;

  // Sequence each request and own both handshakes.
  bpgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Hold configuration, decode coordinates, update the model memory.
  bpgs_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_PAD     (MAX_PAD),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/border_pad_gather_scatter_tb.sv =====
// Self-checking testbench for the border padding gather/scatter block.
`timescale 1ns / 1ps

module border_pad_gather_scatter_tb;
  import bpgs_pkg::*;

  // Sizes of the model image as built into the block.
  localparam int unsigned MODEL_W = 128;
  localparam int unsigned MODEL_H = 128;
  localparam int unsigned PAD_MAX = 16;
  localparam int unsigned IMG_DEPTH = MODEL_W * MODEL_H;

  // Action code that the block must treat as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Stimulus shape.
  localparam int SWEEP_FRAMES = 12;
  localparam int SWEEP_ITEMS = 110;
  localparam int STEADY_ITEMS = 150;
  localparam int BURST_ITEMS = 30;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT = 21;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_data;

  border_pad_gather_scatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block's registers and model image.
  logic [7:0] cfg_w = RST_WIDTH;
  logic [7:0] cfg_h = RST_HEIGHT;
  logic [4:0] cfg_p = RST_PAD;
  logic       cfg_m = RST_MODE;
  logic signed [SAMPLE_W-1:0] model_img [0:IMG_DEPTH-1];
  bit img_written [0:IMG_DEPTH-1];

  // Responses predicted for accepted requests, oldest first.
  out_rsp_t rsp_pending[$];

  int mismatch_cnt = 0;
  int checked_cnt = 0;
  int n_req = 0;
  int n_frames = 0;
  int n_sat = 0;
  int n_border = 0;

  // Shared between the test tasks and the receiver process.
  bit steady = 1'b0;
  bit rx_hold_arm = 1'b0;
  int rx_hold_left = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Effective frame sizes: out-of-range register values clamp to the legal span.
  function automatic void eff_dims(output int unsigned w, output int unsigned h,
                                   output int unsigned p);
    w = (cfg_w == 0) ? 1 : ((cfg_w > MODEL_W) ? MODEL_W : cfg_w);
    h = (cfg_h == 0) ? 1 : ((cfg_h > MODEL_H) ? MODEL_H : cfg_h);
    p = (cfg_p > PAD_MAX) ? PAD_MAX : cfg_p;
  endfunction

  // Map a padded coordinate to the clamped model cell it touches.
  function automatic void locate(input in_req_t req, output bit in_frame, output bit brd,
                                 output int unsigned mr, output int unsigned mc);
    int unsigned w, h, p, r, c;
    eff_dims(w, h, p);
    r = req.row;
    c = req.col;
    in_frame = (r < h + 2 * p) && (c < w + 2 * p);
    brd = (r < p) || (r - p >= h) || (c < p) || (c - p >= w);
    mr = (r < p) ? 0 : ((r - p >= h) ? h - 1 : r - p);
    mc = (c < p) ? 0 : ((c - p >= w) ? w - 1 : c - p);
  endfunction

  // Work out the response to one request and apply its effect on the image.
  function automatic out_rsp_t predict_pad_access(input in_req_t req);
    bit in_frame, brd;
    int unsigned mr, mc, idx;
    logic [SAMPLE_W:0] sum;
    out_rsp_t rsp;
    rsp = '0;
    n_req++;
    locate(req, in_frame, brd, mr, mc);
    if (!in_frame) begin
      rsp.status = ST_RANGE;
      return rsp;
    end
    idx = mr * MODEL_W + mc;
    rsp.in_border = brd;
    if (brd) n_border++;
    case (req.action)
      ACT_WRITE: begin
        if (brd) begin
          rsp.status = ST_RANGE;
        end else begin
          model_img[idx] = req.sample_in;
          img_written[idx] = 1'b1;
          rsp.sample_out = req.sample_in;
        end
      end
      ACT_READ: begin
        if (!brd || cfg_m) rsp.sample_out = model_img[idx];
      end
      ACT_ACCUM: begin
        // Zero mode drops border samples; otherwise add into the clamped cell.
        if (!brd || cfg_m) begin
          sum = {model_img[idx][SAMPLE_W-1], model_img[idx]}
              + {req.sample_in[SAMPLE_W-1], req.sample_in};
          if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            rsp.status = ST_SAT;
            rsp.sample_out = sum[SAMPLE_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            n_sat++;
          end else begin
            rsp.sample_out = sum[SAMPLE_W-1:0];
          end
          model_img[idx] = rsp.sample_out;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic in_req_t mk_req(input logic [ACT_W-1:0] act, input int unsigned row,
                                     input int unsigned col, input logic [SAMPLE_W-1:0] smp);
    in_req_t req;
    req.action = act;
    req.row = 8'(row);
    req.col = 8'(col);
    req.sample_in = smp;
    return req;
  endfunction

  // Pick a coordinate on one axis: mostly inside the frame, often on the
  // border seams, sometimes beyond the frame up to the top of the field.
  function automatic int unsigned pick_coord(input int unsigned n, input int unsigned p);
    int unsigned f, roll;
    f = n + 2 * p;
    roll = $urandom_range(99);
    if (roll < 65) return $urandom_range(f - 1);
    if (roll < 85) begin
      case ($urandom_range(5))
        0: return 0;
        1: return (p == 0) ? 0 : p - 1;
        2: return p;
        3: return p + n - 1;
        4: return p + n;
        default: return f - 1;
      endcase
    end
    return $urandom_range(255, f);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return $urandom;
    if (roll < 75) begin
      case ($urandom_range(6))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h7FFF_0000;
        3: return 32'hFFFF_0000;
        4: return 32'h0000_0000;
        5: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    // Small Q16.16 values around zero.
    return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
  endfunction

  // Random request; a quarter reuse the previous cell to hit back-to-back
  // updates of one entry.
  function automatic in_req_t random_req(input in_req_t prev);
    int unsigned w, h, p, roll;
    in_req_t req;
    eff_dims(w, h, p);
    roll = $urandom_range(99);
    req.action = (roll < 30) ? ACT_WRITE : (roll < 62) ? ACT_READ :
                 (roll < 95) ? ACT_ACCUM : ACT_UNUSED;
    if ($urandom_range(99) < 25) begin
      req.row = prev.row;
      req.col = prev.col;
    end else begin
      req.row = 8'(pick_coord(h, p));
      req.col = 8'(pick_coord(w, p));
    end
    req.sample_in = pick_sample();
    return req;
  endfunction

  // Offer one request and hold it until accepted. Called and returns at a
  // falling edge; valid drops only across a gap, so it never toggles in one step.
  task automatic send_req(input in_req_t req);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_pending.push_back(predict_pad_access(req));
    @(negedge clk);
  endtask

  // Send a request; first seed its target cell when it would read a cell
  // that was never written.
  task automatic issue(input in_req_t req);
    bit in_frame, brd;
    int unsigned mr, mc, w, h, p;
    locate(req, in_frame, brd, mr, mc);
    if (in_frame && (req.action == ACT_READ || req.action == ACT_ACCUM) && (!brd || cfg_m)
        && !img_written[mr * MODEL_W + mc]) begin
      eff_dims(w, h, p);
      send_req(mk_req(ACT_WRITE, mr + p, mc + p, pick_sample()));
    end
    send_req(req);
  endtask

  // Drop valid and wait until every predicted response has been checked.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(negedge clk); while (rsp_pending.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all four registers back to back; only while the block is idle.
  task automatic set_frame(input logic [7:0] w, input logic [7:0] h,
                           input logic [7:0] pd, input logic [7:0] md);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_addr <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_addr <= CFG_PAD;
    cfg_wdata <= pd;
    @(negedge clk);
    cfg_addr <= CFG_MODE;
    cfg_wdata <= md;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_w = w;
    cfg_h = h;
    cfg_p = pd[4:0];
    cfg_m = md[0];
    n_frames++;
  endtask

  // Switch idling off or on; flip it at a rising edge so the receiver sees
  // the change cleanly at the next falling edge. Call only with valid low.
  task automatic set_steady(input bit on);
    @(posedge clk);
    steady = on;
    @(negedge clk);
  endtask

  // Reset defaults: saturation both ways at opposite corners, off-frame
  // coordinates on each axis and the unused action.
  task automatic test_reset_defaults();
    issue(mk_req(ACT_WRITE, 0, 0, 32'h7FFF_FFFF));
    issue(mk_req(ACT_READ, 0, 0, 32'h0));
    issue(mk_req(ACT_ACCUM, 0, 0, 32'h0000_0001));
    issue(mk_req(ACT_WRITE, 127, 127, 32'h8000_0000));
    issue(mk_req(ACT_ACCUM, 127, 127, 32'hFFFF_FFFF));
    issue(mk_req(ACT_READ, 128, 5, 32'h0));
    issue(mk_req(ACT_READ, 5, 255, 32'hFFFF_FFFF));
    issue(mk_req(ACT_UNUSED, 10, 10, 32'h1234_5678));
    wait_results_done();
  endtask

  // Small 3x2 image with a 2-cell border, first in zero mode, then replicate.
  task automatic test_border_cases();
    set_frame(8'd3, 8'd2, 8'd2, 8'd0);
    issue(mk_req(ACT_WRITE, 2, 2, 32'h0001_8000));
    issue(mk_req(ACT_WRITE, 3, 4, 32'hFFFF_0000));
    // Write in the border: refused.
    issue(mk_req(ACT_WRITE, 0, 0, 32'h0000_1000));
    // Zero border reads as 0.
    issue(mk_req(ACT_READ, 0, 6, 32'h0));
    // Zero-mode accumulate in the border: sample dropped.
    issue(mk_req(ACT_ACCUM, 5, 0, 32'h0001_0000));
    issue(mk_req(ACT_READ, 6, 0, 32'h0));
    issue(mk_req(ACT_UNUSED, 1, 1, 32'hFFFF_FFFF));
    wait_results_done();
    set_frame(8'd3, 8'd2, 8'd2, 8'd1);
    // Replicate: corners read the nearest edge cell.
    issue(mk_req(ACT_READ, 0, 0, 32'h0));
    issue(mk_req(ACT_READ, 5, 6, 32'h0));
    issue(mk_req(ACT_ACCUM, 0, 6, 32'h0000_4000));
    issue(mk_req(ACT_ACCUM, 1, 1, 32'h7FFF_FFFF));
    issue(mk_req(ACT_ACCUM, 5, 0, 32'h8000_0000));
    issue(mk_req(ACT_ACCUM, 5, 0, 32'h8000_0000));
    issue(mk_req(ACT_READ, 2, 2, 32'h0));
    wait_results_done();
  endtask

  // Random traffic across many frame settings, the extremes among them.
  task automatic test_random_sweep();
    in_req_t prev;
    logic [7:0] w, h, pd, md;
    prev = mk_req(ACT_READ, 0, 0, 32'h0);
    for (int s = 0; s < SWEEP_FRAMES; s++) begin
      case (s)
        // Oversized values clamp to the largest frame.
        0: begin w = 8'hFF; h = 8'd200; pd = 8'hFF; md = 8'hFF; end
        // Zero sizes clamp to a single cell.
        1: begin w = 8'd0; h = 8'd0; pd = 8'd0; md = 8'hFE; end
        2: begin w = 8'd128; h = 8'd128; pd = 8'd16; md = 8'd1; end
        3: begin w = 8'd1; h = 8'd128; pd = 8'd16; md = 8'd0; end
        default: begin
          w = 8'($urandom_range(1, 12));
          h = 8'($urandom_range(1, 12));
          pd = 8'($urandom_range(0, 4)) | 8'($urandom_range(7) << 5);
          if (s % 4 == 0) pd[4:0] = 5'($urandom_range(17, 31));
          md = 8'($urandom_range(255));
        end
      endcase
      set_frame(w, h, pd, md);
      repeat (SWEEP_ITEMS) begin
        prev = random_req(prev);
        issue(prev);
      end
      wait_results_done();
    end
  endtask

  // Full-rate stretch: neither side idles.
  task automatic test_steady_burst();
    in_req_t prev;
    set_frame(8'd4, 8'd3, 8'd1, 8'd1);
    set_steady(1'b1);
    prev = mk_req(ACT_ACCUM, 1, 1, 32'h0);
    repeat (STEADY_ITEMS) begin
      prev = random_req(prev);
      issue(prev);
    end
    wait_results_done();
    set_steady(1'b0);
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  // and stalls its input; the sender pauses until all responses are in, then sends a second burst.
  task automatic test_backpressure();
    in_req_t prev;
    set_frame(8'd5, 8'd4, 8'd2, 8'd1);
    @(posedge clk);
    rx_hold_arm = 1'b1;
    @(negedge clk);
    prev = mk_req(ACT_WRITE, 2, 2, 32'h0);
    repeat (BURST_ITEMS) begin
      prev = random_req(prev);
      issue(prev);
    end
    wait_results_done();
    repeat (BURST_ITEMS) begin
      prev = random_req(prev);
      issue(prev);
    end
    wait_results_done();
  endtask

  // Receiver: random stalls, or a counted hold-off when armed.
  always @(negedge clk) begin
    if (rx_hold_arm) begin
      rx_hold_arm = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each delivered response with the oldest prediction.
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rsp_pending.size() == 0) begin
        flag_mismatch("response arrived with nothing pending");
      end else begin
        want = rsp_pending.pop_front();
        checked_cnt++;
        if (out_data.sample_out !== want.sample_out)
          flag_mismatch($sformatf("sample_out got %h want %h",
                                  out_data.sample_out, want.sample_out));
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.in_border !== want.in_border)
          flag_mismatch($sformatf("in_border got %b want %b",
                                  out_data.in_border, want.in_border));
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("border_pad_gather_scatter_tb NOT OK");
    $finish;
  end

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_border_cases();
    test_random_sweep();
    test_steady_burst();
    test_backpressure();
    wait_results_done();

    if (rsp_pending.size() != 0) flag_mismatch("predicted responses never arrived");
    $display("covered %0d requests (%0d checked) over %0d frame settings", n_req,
             checked_cnt, n_frames);
    $display("with %0d border hits and %0d saturated accumulates", n_border, n_sat);
    if (mismatch_cnt == 0) begin
      $display("border_pad_gather_scatter_tb OK");
    end else begin
      $display("border_pad_gather_scatter_tb NOT OK");
    end
    $finish;
  end

endmodule
